// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types and constants shared by the SD card SPI host sequencer files.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	localparam int BLOCK_BYTES    = 512;
	localparam int RESPONSE_BYTES = 5;
	localparam int BUF_AW         = $clog2(BLOCK_BYTES);

	localparam logic [1:0] KIND_REQ = 2'd0;
	localparam logic [1:0] KIND_RX  = 2'd1;
	localparam logic [1:0] KIND_BUF = 2'd2;

	localparam logic [1:0] REQ_INIT  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	localparam logic [1:0] CFG_R1_POLL = 2'd0;
	localparam logic [1:0] CFG_RETRY   = 2'd1;
	localparam logic [1:0] CFG_WARMUP  = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_R1_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_R1_ERROR   = 3'd2;
	localparam logic [2:0] ST_NO_IDLE    = 3'd3;
	localparam logic [2:0] ST_BAD_COND   = 3'd4;
	localparam logic [2:0] ST_REJECTED   = 3'd5;
	localparam logic [2:0] ST_STATUS_BAD = 3'd6;

	localparam logic [7:0] BYTE_IDLE   = 8'hff;
	localparam logic [7:0] TOKEN_START = 8'hfe;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  request;
		logic [31:0] block_index;
		logic [31:0] block_count;
		logic [7:0]  rx_byte;
		logic [8:0]  buffer_index;
		logic [7:0]  buffer_byte;
	} sdspi_in_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       select_active;
		logic [7:0] read_byte;
		logic [8:0] read_index;
		logic       read_valid;
		logic       done_res;
		logic [2:0] status;
		logic       card_v2;
		logic       card_high_capacity;
	} sdspi_out_t;

endpackage

// ===== rtl/core/sdspi_in_if.sv =====
// ----------------------------------------------------------------------------
// sdspi_in_if
// Valid/ready channel carrying input items of the sequencer.
// ----------------------------------------------------------------------------
interface sdspi_in_if;
	logic                  valid;
	logic                  ready;
	sdspi_pkg::sdspi_in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sdspi_out_if.sv =====
// ----------------------------------------------------------------------------
// sdspi_out_if
// Valid/ready channel carrying result items of the sequencer.
// ----------------------------------------------------------------------------
interface sdspi_out_if;
	logic                  valid;
	logic                  ready;
	sdspi_pkg::sdspi_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sd_card_spi_host_sequencer.sv =====
// SD card SPI host sequencer. Each input item (host request, byte received
// from the card, or block buffer write) yields exactly one result item. An
// accepted item is registered, processed by combinational logic and its result
// item is registered in the output register and offered from there; a new item is
// taken every cycle while the output register is free or being drained. The
// throughput is one item per cycle while the output is not stalled, set by the single
// result register; a buffer write lands in the block RAM and the write phase
// prefetches the next buffer byte through its read port.
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer
// SPI mode SD card init, block read, block write and erase sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sd_card_spi_host_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	sdspi_in_if.sink      in_ch,
	sdspi_out_if.source   out_ch,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam int RESP_N = sdspi_pkg::RESPONSE_BYTES;
	localparam int AW     = sdspi_pkg::BUF_AW;

	typedef enum logic [18:0] {
		P_IDLE      = 19'h00001,
		P_WARMUP    = 19'h00002,
		P_CMD0      = 19'h00004,
		P_CMD8      = 19'h00008,
		P_CMD55     = 19'h00010,
		P_ACMD41    = 19'h00020,
		P_CMD58     = 19'h00040,
		P_CMD16     = 19'h00080,
		P_RD_CMD    = 19'h00100,
		P_RD_TOKEN  = 19'h00200,
		P_RD_DATA   = 19'h00400,
		P_WR_CMD    = 19'h00800,
		P_WR_DATA   = 19'h01000,
		P_WR_RESP   = 19'h02000,
		P_WR_BUSY   = 19'h04000,
		P_WR_STATUS = 19'h08000,
		P_ER_START  = 19'h10000,
		P_ER_END    = 19'h20000,
		P_ER_ERASE  = 19'h40000
	} phase_t;

	typedef enum logic [4:0] {
		S_WAIT  = 5'h01,
		S_SEND  = 5'h02,
		S_POLL  = 5'h04,
		S_EXTRA = 5'h08,
		S_BUSY  = 5'h10
	} stage_t;

	// configuration
	logic [15:0] r1_poll_limit_q;
	logic [7:0]  reset_retry_limit_q;
	logic [7:0]  warmup_bytes_q;

	// sequencer state
	phase_t      phase_q, phase_d;
	stage_t      stage_q, stage_d;
	logic [9:0]  byte_cnt_q, byte_cnt_d;
	logic [15:0] poll_cnt_q, poll_cnt_d;
	logic [7:0]  retry_cnt_q, retry_cnt_d;
	logic [7:0]  resp_q [RESP_N], resp_d [RESP_N];
	logic [1:0]  flags_q, flags_d;
	logic [31:0] cur_addr_q, cur_addr_d;
	logic [31:0] end_addr_q, end_addr_d;

	// pipeline
	logic                  v_s1;
	sdspi_pkg::sdspi_in_t  it_s1;
	logic                  v_s2;
	sdspi_pkg::sdspi_out_t res_s2;
	sdspi_pkg::sdspi_out_t res;
	logic                  adv;

	// block buffer with registered read
	logic [7:0]    buf_mem [sdspi_pkg::BLOCK_BYTES];
	logic [7:0]    buf_rd_q;
	logic [AW-1:0] buf_raddr;

	assign adv          = !v_s2 || out_ch.ready;
	assign in_ch.ready  = adv;
	assign out_ch.valid = v_s2;
	assign out_ch.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_poll_limit_q     <= 16'd10000;
			reset_retry_limit_q <= 8'd255;
			warmup_bytes_q      <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				sdspi_pkg::CFG_R1_POLL: r1_poll_limit_q <= cfg_data;
				sdspi_pkg::CFG_RETRY:   reset_retry_limit_q <= cfg_data[7:0];
				sdspi_pkg::CFG_WARMUP:  warmup_bytes_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Buffer writes go straight into the RAM on acceptance so a later write
	// phase sees them. The read port keeps the next byte of a write phase
	// ready: its address follows the byte counter.
	always_ff @(posedge clk) begin
		if (in_ch.valid && adv && in_ch.data.kind == sdspi_pkg::KIND_BUF)
			buf_mem[in_ch.data.buffer_index] <= in_ch.data.buffer_byte;
		buf_rd_q <= buf_mem[buf_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1  <= in_ch.data;
			res_s2 <= res;
		end
	end

	// Read address: byte_cnt-1 of the state being committed. A buffer write
	// in flight at stage 1 also refreshes the prefetch via the next cycle.
	always_comb begin
		if (v_s1 && adv) buf_raddr = AW'(byte_cnt_d - 10'd1);
		else             buf_raddr = AW'(byte_cnt_q - 10'd1);
	end

	function automatic logic [31:0] scale(input logic [31:0] blk, input logic hc);
		return hc ? blk : {blk[31-AW:0], AW'(0)};
	endfunction

	// per-phase command frame
	logic [5:0]  f_op;
	logic [31:0] f_arg;
	logic [6:0]  f_crc;
	logic [7:0]  frame_b;
	logic [2:0]  extra_n;

	always_comb begin
		f_op  = 6'h00;
		f_arg = 32'h0;
		f_crc = 7'h7f;
		case (phase_q)
			P_CMD0:      begin f_op = 6'h00; f_crc = 7'h4a; end
			P_CMD8:      begin f_op = 6'h08; f_arg = 32'h1aa; f_crc = 7'h43; end
			P_CMD55:     f_op = 6'h37;
			P_ACMD41:    begin f_op = 6'h29; f_arg = {1'b0, flags_q[0], 30'h0}; end
			P_CMD58:     f_op = 6'h3a;
			P_CMD16:     begin f_op = 6'h10; f_arg = 32'h200; end
			P_RD_CMD:    begin f_op = 6'h11; f_arg = cur_addr_q; end
			P_WR_CMD:    begin f_op = 6'h18; f_arg = cur_addr_q; end
			P_WR_STATUS: f_op = 6'h0d;
			P_ER_START:  begin f_op = 6'h20; f_arg = cur_addr_q; end
			P_ER_END:    begin f_op = 6'h21; f_arg = end_addr_q; end
			P_ER_ERASE:  f_op = 6'h26;
			default: ;
		endcase
		case (byte_cnt_q[2:0])
			3'd1:    frame_b = f_arg[31:24];
			3'd2:    frame_b = f_arg[23:16];
			3'd3:    frame_b = f_arg[15:8];
			3'd4:    frame_b = f_arg[7:0];
			default: frame_b = {f_crc, 1'b1};
		endcase
		if (phase_q == P_CMD8 || phase_q == P_CMD58) extra_n = 3'd4;
		else if (phase_q == P_WR_STATUS)             extra_n = 3'd1;
		else                                         extra_n = 3'd0;
	end

	// Main next-state logic. Response bytes are read from resp_d so that the
	// R1 just captured in the poll stage is seen by the completion logic.
	logic [7:0]  rx;
	logic        ac_go, ac_to;
	logic [7:0]  r0;
	logic [15:0] poll_inc;
	logic [7:0]  retry_inc;
	logic [9:0]  cnt_inc;
	logic [2:0]  ex_idx;
	logic [31:0] end_blk;

	always_comb begin
		phase_d    = phase_q;
		stage_d    = stage_q;
		byte_cnt_d = byte_cnt_q;
		poll_cnt_d = poll_cnt_q;
		retry_cnt_d = retry_cnt_q;
		for (int i = 0; i < RESP_N; i++) resp_d[i] = resp_q[i];
		flags_d    = flags_q;
		cur_addr_d = cur_addr_q;
		end_addr_d = end_addr_q;
		res        = '0;
		rx         = it_s1.rx_byte;
		ac_go      = 1'b0;
		ac_to      = 1'b0;
		poll_inc   = poll_cnt_q + 16'd1;
		retry_inc  = retry_cnt_q + 8'd1;
		cnt_inc    = byte_cnt_q + 10'd1;
		ex_idx     = 3'd0;
		end_blk    = it_s1.block_index + it_s1.block_count - 32'd1;

		if (v_s1) begin
			case (it_s1.kind)
				sdspi_pkg::KIND_REQ: begin
					if (phase_q == P_IDLE) begin
						res.tx_valid = 1'b1;
						res.tx_byte  = sdspi_pkg::BYTE_IDLE;
						stage_d = S_WAIT;
						case (it_s1.request)
							sdspi_pkg::REQ_INIT: begin
								flags_d = 2'b00;
								retry_cnt_d = 8'd0;
								if (warmup_bytes_q == 8'd0) phase_d = P_CMD0;
								else begin
									phase_d = P_WARMUP;
									byte_cnt_d = 10'd1;
								end
							end
							sdspi_pkg::REQ_READ: begin
								cur_addr_d = scale(it_s1.block_index, flags_q[1]);
								phase_d = P_RD_CMD;
							end
							sdspi_pkg::REQ_WRITE: begin
								cur_addr_d = scale(it_s1.block_index, flags_q[1]);
								phase_d = P_WR_CMD;
							end
							default: begin
								cur_addr_d = scale(it_s1.block_index, flags_q[1]);
								end_addr_d = scale(end_blk, flags_q[1]);
								phase_d = P_ER_START;
							end
						endcase
					end
				end
				sdspi_pkg::KIND_RX: begin
					case (phase_q)
						P_IDLE: ;
						P_WARMUP: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = sdspi_pkg::BYTE_IDLE;
							if (byte_cnt_q < {2'b0, warmup_bytes_q}) byte_cnt_d = cnt_inc;
							else begin
								retry_cnt_d = 8'd0;
								phase_d = P_CMD0;
								stage_d = S_WAIT;
							end
						end
						P_RD_TOKEN: begin
							if (rx == sdspi_pkg::TOKEN_START) begin
								phase_d = P_RD_DATA;
								byte_cnt_d = 10'd0;
							end
							res.tx_valid = 1'b1;
							res.tx_byte  = sdspi_pkg::BYTE_IDLE;
						end
						P_RD_DATA: begin
							if (byte_cnt_q < 10'(sdspi_pkg::BLOCK_BYTES)) begin
								res.read_byte  = rx;
								res.read_index = byte_cnt_q[AW-1:0];
								res.read_valid = 1'b1;
							end
							byte_cnt_d = cnt_inc;
							if (cnt_inc < 10'(sdspi_pkg::BLOCK_BYTES + 2)) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = sdspi_pkg::BYTE_IDLE;
							end else begin
								phase_d = P_IDLE;
								stage_d = S_WAIT;
								res.done_res = 1'b1;
							end
						end
						P_WR_DATA: begin
							res.tx_valid = 1'b1;
							if (byte_cnt_q >= 10'(sdspi_pkg::BLOCK_BYTES + 3)) begin
								phase_d = P_WR_RESP;
								res.tx_byte = sdspi_pkg::BYTE_IDLE;
							end else begin
								if (byte_cnt_q <= 10'(sdspi_pkg::BLOCK_BYTES))
									res.tx_byte = buf_rd_q;
								else
									res.tx_byte = sdspi_pkg::BYTE_IDLE;
								byte_cnt_d = cnt_inc;
							end
						end
						P_WR_RESP: begin
							if (rx[4:0] != 5'h05) begin
								phase_d = P_IDLE;
								stage_d = S_WAIT;
								res.done_res = 1'b1;
								res.status = sdspi_pkg::ST_REJECTED;
							end else begin
								phase_d = P_WR_BUSY;
								res.tx_valid = 1'b1;
								res.tx_byte  = sdspi_pkg::BYTE_IDLE;
							end
						end
						P_WR_BUSY: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = sdspi_pkg::BYTE_IDLE;
							if (rx != 8'h00) begin
								phase_d = P_WR_STATUS;
								stage_d = S_WAIT;
							end
						end
						default: begin
							case (stage_q)
								S_WAIT: begin
									res.tx_valid = 1'b1;
									if (rx == sdspi_pkg::BYTE_IDLE) begin
										stage_d = S_SEND;
										res.tx_byte = {2'b01, f_op};
										byte_cnt_d = 10'd1;
									end else res.tx_byte = sdspi_pkg::BYTE_IDLE;
								end
								S_SEND: begin
									res.tx_valid = 1'b1;
									if (byte_cnt_q < 10'd6) begin
										res.tx_byte = frame_b;
										byte_cnt_d = cnt_inc;
									end else begin
										stage_d = S_POLL;
										poll_cnt_d = 16'd0;
										res.tx_byte = sdspi_pkg::BYTE_IDLE;
									end
								end
								S_POLL: begin
									resp_d[0] = rx;
									if (!rx[7]) begin
										if (extra_n != 3'd0 && !rx[2]) begin
											stage_d = S_EXTRA;
											byte_cnt_d = 10'd0;
											res.tx_valid = 1'b1;
											res.tx_byte = sdspi_pkg::BYTE_IDLE;
										end else if (phase_q == P_ER_ERASE) begin
											stage_d = S_BUSY;
											res.tx_valid = 1'b1;
											res.tx_byte = sdspi_pkg::BYTE_IDLE;
										end else ac_go = 1'b1;
									end else begin
										poll_cnt_d = poll_inc;
										if (poll_inc >= r1_poll_limit_q) begin
											ac_go = 1'b1;
											ac_to = 1'b1;
										end else begin
											res.tx_valid = 1'b1;
											res.tx_byte = sdspi_pkg::BYTE_IDLE;
										end
									end
								end
								S_EXTRA: begin
									ex_idx = 3'(byte_cnt_q[1:0]) + 3'd1;
									if (ex_idx < 3'(RESP_N)) resp_d[ex_idx] = rx;
									else resp_d[0] = rx;
									byte_cnt_d = cnt_inc;
									if (cnt_inc >= 10'(extra_n)) ac_go = 1'b1;
									else begin
										res.tx_valid = 1'b1;
										res.tx_byte = sdspi_pkg::BYTE_IDLE;
									end
								end
								default: begin
									if (rx == 8'h00) begin
										res.tx_valid = 1'b1;
										res.tx_byte = sdspi_pkg::BYTE_IDLE;
									end else ac_go = 1'b1;
								end
							endcase
						end
					endcase
				end
				default: ;
			endcase
		end

		// command completion
		r0 = resp_d[0];
		if (ac_go) begin
			res.tx_byte  = sdspi_pkg::BYTE_IDLE;
			res.tx_valid = 1'b1;
			stage_d = S_WAIT;
			if (phase_q == P_CMD0) begin
				if (!ac_to && r0[0]) phase_d = P_CMD8;
				else begin
					retry_cnt_d = retry_inc;
					if (retry_inc >= reset_retry_limit_q) begin
						phase_d = P_IDLE;
						res.tx_valid = 1'b0;
						res.done_res = 1'b1;
						res.status = sdspi_pkg::ST_NO_IDLE;
					end
				end
			end else if (ac_to) begin
				phase_d = P_IDLE;
				res.tx_valid = 1'b0;
				res.done_res = 1'b1;
				res.status = sdspi_pkg::ST_R1_TIMEOUT;
			end else begin
				res.done_res = 1'b1;
				res.status = sdspi_pkg::ST_OK;
				case (phase_q)
					P_CMD8: begin
						res.done_res = 1'b0;
						phase_d = P_CMD55;
						if (!r0[2]) begin
							flags_d[0] = 1'b1;
							if (r0[7:1] != 7'h0 || resp_d[4] != 8'haa
							    || resp_d[3][3:0] != 4'h1) begin
								res.done_res = 1'b1;
								res.status = sdspi_pkg::ST_BAD_COND;
							end
						end
					end
					P_CMD55: begin res.done_res = 1'b0; phase_d = P_ACMD41; end
					P_ACMD41: begin
						res.done_res = 1'b0;
						if (r0[0]) phase_d = P_CMD55;
						else if (flags_q[0]) phase_d = P_CMD58;
						else if (flags_q[1]) res.done_res = 1'b1;
						else phase_d = P_CMD16;
					end
					P_CMD58: begin
						res.done_res = 1'b0;
						if (!r0[2] && resp_d[1][7:6] == 2'b11) flags_d[1] = 1'b1;
						if (flags_d[1]) res.done_res = 1'b1;
						else phase_d = P_CMD16;
					end
					P_CMD16:
						if (r0 != 8'h0) res.status = sdspi_pkg::ST_R1_ERROR;
					P_RD_CMD:
						if (r0 != 8'h0) res.status = sdspi_pkg::ST_R1_ERROR;
						else begin res.done_res = 1'b0; phase_d = P_RD_TOKEN; end
					P_WR_CMD:
						if (r0 != 8'h0) res.status = sdspi_pkg::ST_R1_ERROR;
						else begin
							res.done_res = 1'b0;
							phase_d = P_WR_DATA;
							byte_cnt_d = 10'd1;
							res.tx_byte = sdspi_pkg::TOKEN_START;
						end
					P_WR_STATUS:
						if (r0 != 8'h0 || resp_d[1] != 8'h0)
							res.status = sdspi_pkg::ST_STATUS_BAD;
					P_ER_START:
						if (r0 != 8'h0) res.status = sdspi_pkg::ST_R1_ERROR;
						else begin res.done_res = 1'b0; phase_d = P_ER_END; end
					P_ER_END:
						if (r0 != 8'h0) res.status = sdspi_pkg::ST_R1_ERROR;
						else begin res.done_res = 1'b0; phase_d = P_ER_ERASE; end
					P_ER_ERASE:
						if (r0 != 8'h0) res.status = sdspi_pkg::ST_R1_ERROR;
					default: ;
				endcase
				if (res.done_res) begin
					phase_d = P_IDLE;
					res.tx_valid = 1'b0;
					res.tx_byte = 8'h00;
				end
			end
			if (!res.tx_valid) res.tx_byte = 8'h00;
		end

		res.select_active      = phase_d != P_IDLE && phase_d != P_WARMUP;
		res.card_v2            = flags_d[0];
		res.card_high_capacity = flags_d[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_IDLE;
			stage_q     <= S_WAIT;
			byte_cnt_q  <= '0;
			poll_cnt_q  <= '0;
			retry_cnt_q <= '0;
			for (int i = 0; i < RESP_N; i++) resp_q[i] <= '0;
			flags_q     <= '0;
			cur_addr_q  <= '0;
			end_addr_q  <= '0;
		end else if (v_s1 && adv) begin
			phase_q     <= phase_d;
			stage_q     <= stage_d;
			byte_cnt_q  <= byte_cnt_d;
			poll_cnt_q  <= poll_cnt_d;
			retry_cnt_q <= retry_cnt_d;
			for (int i = 0; i < RESP_N; i++) resp_q[i] <= resp_d[i];
			flags_q     <= flags_d;
			cur_addr_q  <= cur_addr_d;
			end_addr_q  <= end_addr_d;
		end
	end

	`ASSERT_CLK(a_phase_onehot, $onehot(phase_q), "phase register not one-hot")
	`ASSERT_IMPL(a_done_no_tx, v_s2 && res_s2.done_res, !res_s2.tx_valid,
		"done item also starts an exchange")
	`ASSERT_IMPL(a_stall_hold, v_s2 && !out_ch.ready, ##1 $stable(res_s2),
		"stalled result changed")
	`ASSERT_IMPL(a_idle_no_select, phase_q == P_IDLE && !v_s1, !res.select_active || !v_s1,
		"select active while idle")

endmodule

// ===== dv/sd_card_spi_host_sequencer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer_test
// Self-checking bench for the SD card SPI host sequencer. A card responder
// picks each received byte from the predicted sequencer state, so init, read,
// write and erase run to their ends; every result item is compared field by
// field against an in-bench model of the sequencer, or against the given result for typed directed items.
// ----------------------------------------------------------------------------
module sd_card_spi_host_sequencer_test;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [1:0] REQ_ERASE = 2'd3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RAND_ITEMS  = 100;

	typedef enum logic [5:0] {
		PH_IDLE, PH_WARMUP, PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_CMD58, PH_CMD16,
		PH_RD_CMD, PH_RD_TOKEN, PH_RD_DATA, PH_WR_CMD, PH_WR_DATA, PH_WR_RESP,
		PH_WR_BUSY, PH_WR_STATUS, PH_ER_START, PH_ER_END, PH_ER_ERASE
	} phase_e;
	typedef enum logic [2:0] {SG_WAIT, SG_SEND, SG_POLL, SG_EXTRA, SG_BUSY} stage_e;

	typedef struct {
		sdspi_pkg::sdspi_in_t  it;
		bit                    typed;
		sdspi_pkg::sdspi_out_t res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	sdspi_in_if  in_ch();
	sdspi_out_if out_ch();

	sd_card_spi_host_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// sequencer copy
	logic [15:0] poll_lim;
	logic [7:0]  retry_lim;
	logic [7:0]  warm_len;
	phase_e      ph;
	stage_e      sg;
	logic [9:0]  bcnt;
	logic [15:0] pcnt;
	logic [7:0]  rcnt;
	logic [7:0]  resp [sdspi_pkg::RESPONSE_BYTES];
	logic [1:0]  flags;
	logic [31:0] cur_addr;
	logic [31:0] end_addr;
	logic [7:0]  blk_buf [sdspi_pkg::BLOCK_BYTES];
	sdspi_pkg::sdspi_out_t res;

	sdspi_pkg::sdspi_out_t seq_results_q[$];
	int          errors;
	int          cycles;
	bit          burst;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void send(input logic [7:0] b);
		res.tx_byte  = b;
		res.tx_valid = 1'b1;
	endfunction

	function automatic void finish_req(input logic [2:0] st);
		ph = PH_IDLE;
		sg = SG_WAIT;
		res.done_res = 1'b1;
		res.status = st;
	endfunction

	function automatic void start_cmd(input phase_e p);
		ph = p;
		sg = SG_WAIT;
		send(sdspi_pkg::BYTE_IDLE);
	endfunction

	function automatic logic [31:0] to_addr(input logic [31:0] blk);
		return flags[1] ? blk : {blk[22:0], 9'd0};
	endfunction

	function automatic logic [7:0] frame_byte(input int idx);
		logic [5:0]  op;
		logic [7:0]  crc;
		logic [31:0] arg;
		op = 6'h00;
		crc = 8'hff;
		arg = 32'd0;
		case (ph)
			PH_CMD0: begin op = 6'h00; crc = 8'h4a; end
			PH_CMD8: begin op = 6'h08; arg = 32'h1aa; crc = 8'h43; end
			PH_CMD55: op = 6'h37;
			PH_ACMD41: begin op = 6'h29; arg = flags[0] ? 32'h4000_0000 : 32'd0; end
			PH_CMD58: op = 6'h3a;
			PH_CMD16: begin op = 6'h10; arg = 32'h200; end
			PH_RD_CMD: begin op = 6'h11; arg = cur_addr; end
			PH_WR_CMD: begin op = 6'h18; arg = cur_addr; end
			PH_WR_STATUS: op = 6'h0d;
			PH_ER_START: begin op = 6'h20; arg = cur_addr; end
			PH_ER_END: begin op = 6'h21; arg = end_addr; end
			PH_ER_ERASE: op = 6'h26;
			default: ;
		endcase
		if (idx == 0)
			return {2'b01, op};
		if (idx < 5)
			return 8'(arg >> (8 * (4 - idx)));
		return {crc[6:0], 1'b1};
	endfunction

	function automatic int extra_len();
		if (ph == PH_CMD8 || ph == PH_CMD58)
			return 4;
		if (ph == PH_WR_STATUS)
			return 1;
		return 0;
	endfunction

	function automatic void init_ready();
		if (flags[1])
			finish_req(sdspi_pkg::ST_OK);
		else
			start_cmd(PH_CMD16);
	endfunction

	function automatic void after_cmd(input bit tmo);
		logic [7:0] r0;
		r0 = resp[0];
		if (ph == PH_CMD0) begin
			if (!tmo && r0[0]) begin
				start_cmd(PH_CMD8);
				return;
			end
			rcnt++;
			if (rcnt >= retry_lim)
				finish_req(sdspi_pkg::ST_NO_IDLE);
			else
				start_cmd(PH_CMD0);
			return;
		end
		if (tmo) begin
			finish_req(sdspi_pkg::ST_R1_TIMEOUT);
			return;
		end
		case (ph)
			PH_CMD8: begin
				if (!r0[2]) begin
					flags[0] = 1'b1;
					if ((r0 & 8'hfe) != 0 || resp[4] != 8'haa || resp[3][3:0] != 4'h1) begin
						finish_req(sdspi_pkg::ST_BAD_COND);
						return;
					end
				end
				start_cmd(PH_CMD55);
			end
			PH_CMD55: start_cmd(PH_ACMD41);
			PH_ACMD41: begin
				if (r0[0])
					start_cmd(PH_CMD55);
				else if (flags[0])
					start_cmd(PH_CMD58);
				else
					init_ready();
			end
			PH_CMD58: begin
				if (!r0[2] && resp[1][7:6] == 2'b11)
					flags[1] = 1'b1;
				init_ready();
			end
			PH_CMD16: finish_req(r0 != 0 ? sdspi_pkg::ST_R1_ERROR : sdspi_pkg::ST_OK);
			PH_RD_CMD: begin
				if (r0 != 0) begin
					finish_req(sdspi_pkg::ST_R1_ERROR);
				end else begin
					ph = PH_RD_TOKEN;
					send(sdspi_pkg::BYTE_IDLE);
				end
			end
			PH_WR_CMD: begin
				if (r0 != 0) begin
					finish_req(sdspi_pkg::ST_R1_ERROR);
				end else begin
					ph = PH_WR_DATA;
					bcnt = 10'd1;
					send(sdspi_pkg::TOKEN_START);
				end
			end
			PH_WR_STATUS: finish_req((r0 != 0 || resp[1] != 0) ? sdspi_pkg::ST_STATUS_BAD
				: sdspi_pkg::ST_OK);
			PH_ER_START: begin
				if (r0 != 0) finish_req(sdspi_pkg::ST_R1_ERROR);
				else start_cmd(PH_ER_END);
			end
			PH_ER_END: begin
				if (r0 != 0) finish_req(sdspi_pkg::ST_R1_ERROR);
				else start_cmd(PH_ER_ERASE);
			end
			PH_ER_ERASE: finish_req(r0 != 0 ? sdspi_pkg::ST_R1_ERROR : sdspi_pkg::ST_OK);
			default: finish_req(sdspi_pkg::ST_OK);
		endcase
	endfunction

	function automatic void cmd_rx(input logic [7:0] rx);
		int n;
		case (sg)
			SG_WAIT: begin
				if (rx == sdspi_pkg::BYTE_IDLE) begin
					sg = SG_SEND;
					send(frame_byte(0));
					bcnt = 10'd1;
				end else begin
					send(sdspi_pkg::BYTE_IDLE);
				end
			end
			SG_SEND: begin
				if (bcnt < 6) begin
					send(frame_byte(int'(bcnt)));
					bcnt++;
				end else begin
					sg = SG_POLL;
					pcnt = 16'd0;
					send(sdspi_pkg::BYTE_IDLE);
				end
			end
			SG_POLL: begin
				resp[0] = rx;
				if (!rx[7]) begin
					n = extra_len();
					if (n != 0 && !rx[2]) begin
						sg = SG_EXTRA;
						bcnt = 10'd0;
						send(sdspi_pkg::BYTE_IDLE);
					end else if (ph == PH_ER_ERASE) begin
						sg = SG_BUSY;
						send(sdspi_pkg::BYTE_IDLE);
					end else begin
						after_cmd(1'b0);
					end
				end else begin
					pcnt++;
					if (pcnt >= poll_lim) after_cmd(1'b1);
					else send(sdspi_pkg::BYTE_IDLE);
				end
			end
			SG_EXTRA: begin
				n = extra_len();
				resp[(1 + int'(bcnt)) % sdspi_pkg::RESPONSE_BYTES] = rx;
				bcnt++;
				if (bcnt >= n) after_cmd(1'b0);
				else send(sdspi_pkg::BYTE_IDLE);
			end
			default: begin
				if (rx == 0) send(sdspi_pkg::BYTE_IDLE);
				else after_cmd(1'b0);
			end
		endcase
	endfunction

	function automatic void card_byte_in(input logic [7:0] rx);
		case (ph)
			PH_IDLE: ;
			PH_WARMUP: begin
				if (bcnt < warm_len) begin
					send(sdspi_pkg::BYTE_IDLE);
					bcnt++;
				end else begin
					rcnt = 8'd0;
					start_cmd(PH_CMD0);
				end
			end
			PH_RD_TOKEN: begin
				if (rx == sdspi_pkg::TOKEN_START) begin
					ph = PH_RD_DATA;
					bcnt = 10'd0;
				end
				send(sdspi_pkg::BYTE_IDLE);
			end
			PH_RD_DATA: begin
				if (bcnt < sdspi_pkg::BLOCK_BYTES) begin
					res.read_byte = rx;
					res.read_index = bcnt[8:0];
					res.read_valid = 1'b1;
				end
				bcnt++;
				if (bcnt < sdspi_pkg::BLOCK_BYTES + 2) send(sdspi_pkg::BYTE_IDLE);
				else finish_req(sdspi_pkg::ST_OK);
			end
			PH_WR_DATA: begin
				if (bcnt >= sdspi_pkg::BLOCK_BYTES + 3) begin
					ph = PH_WR_RESP;
					send(sdspi_pkg::BYTE_IDLE);
				end else begin
					if (bcnt <= sdspi_pkg::BLOCK_BYTES)
						send(blk_buf[9'(bcnt - 10'd1)]);
					else
						send(sdspi_pkg::BYTE_IDLE);
					bcnt++;
				end
			end
			PH_WR_RESP: begin
				if (rx[4:0] != 5'h05) begin
					finish_req(sdspi_pkg::ST_REJECTED);
				end else begin
					ph = PH_WR_BUSY;
					send(sdspi_pkg::BYTE_IDLE);
				end
			end
			PH_WR_BUSY: begin
				if (rx == 0) send(sdspi_pkg::BYTE_IDLE);
				else start_cmd(PH_WR_STATUS);
			end
			default: cmd_rx(rx);
		endcase
	endfunction

	function automatic void host_request(input logic [1:0] req, input logic [31:0] blk,
			input logic [31:0] cnt);
		if (ph != PH_IDLE)
			return;
		case (req)
			sdspi_pkg::REQ_INIT: begin
				flags = 2'b00;
				rcnt = 8'd0;
				if (warm_len == 0) begin
					start_cmd(PH_CMD0);
				end else begin
					ph = PH_WARMUP;
					bcnt = 10'd1;
					send(sdspi_pkg::BYTE_IDLE);
				end
			end
			sdspi_pkg::REQ_READ: begin
				cur_addr = to_addr(blk);
				start_cmd(PH_RD_CMD);
			end
			sdspi_pkg::REQ_WRITE: begin
				cur_addr = to_addr(blk);
				start_cmd(PH_WR_CMD);
			end
			default: begin
				cur_addr = to_addr(blk);
				end_addr = to_addr(blk + cnt - 32'd1);
				start_cmd(PH_ER_START);
			end
		endcase
	endfunction

	function automatic sdspi_pkg::sdspi_out_t seq_step(input sdspi_pkg::sdspi_in_t it);
		res = '0;
		case (it.kind)
			sdspi_pkg::KIND_REQ: host_request(it.request, it.block_index, it.block_count);
			sdspi_pkg::KIND_RX: card_byte_in(it.rx_byte);
			sdspi_pkg::KIND_BUF: blk_buf[it.buffer_index] = it.buffer_byte;
			default: ;
		endcase
		res.select_active = (ph != PH_IDLE && ph != PH_WARMUP);
		res.card_v2 = flags[0];
		res.card_high_capacity = flags[1];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sdspi_pkg::sdspi_in_t mk_in(input logic [1:0] kind,
			input logic [1:0] req, input logic [31:0] blk, input logic [31:0] cnt,
			input logic [7:0] rx, input logic [8:0] bidx, input logic [7:0] bbyte);
		sdspi_pkg::sdspi_in_t it;
		it.kind = kind;
		it.request = req;
		it.block_index = blk;
		it.block_count = cnt;
		it.rx_byte = rx;
		it.buffer_index = bidx;
		it.buffer_byte = bbyte;
		return it;
	endfunction

	function automatic sdspi_pkg::sdspi_out_t mk_res(input logic [7:0] tx, input logic txv,
			input logic sel, input logic done, input logic [2:0] st);
		sdspi_pkg::sdspi_out_t o;
		o = '0;
		o.tx_byte = tx;
		o.tx_valid = txv;
		o.select_active = sel;
		o.done_res = done;
		o.status = st;
		return o;
	endfunction

	// card behavior, mostly well-formed for the current step of the sequence
	function automatic logic [7:0] card_reply();
		int r;
		logic [7:0] any;
		r = $urandom_range(0, 99);
		any = 8'($urandom);
		case (ph)
			PH_RD_TOKEN: return r < 30 ? sdspi_pkg::BYTE_IDLE
				: (r < 85 ? sdspi_pkg::TOKEN_START : any);
			PH_WR_RESP: return r < 85 ? {any[7:5], 5'h05} : any;
			PH_WR_BUSY: return r < 60 ? 8'h00 : any;
			PH_WARMUP, PH_RD_DATA, PH_WR_DATA: return any;
			default: ;
		endcase
		case (sg)
			SG_WAIT: return r < 75 ? sdspi_pkg::BYTE_IDLE : any;
			SG_SEND: return any;
			SG_POLL: begin
				if (r < 15)
					return {1'b1, any[6:0]};
				if (r < 25)
					return {1'b0, any[6:0]};
				case (ph)
					PH_CMD0: return 8'h01;
					PH_CMD8: return r < 75 ? 8'h01 : 8'h05;
					PH_CMD55: return 8'h01;
					PH_ACMD41: return r < 60 ? 8'h01 : 8'h00;
					default: return 8'h00;
				endcase
			end
			SG_EXTRA: begin
				if (r < 10)
					return any;
				if (ph == PH_CMD8 && bcnt == 2)
					return {any[7:4], 4'h1};
				if (ph == PH_CMD8 && bcnt == 3)
					return 8'haa;
				if (ph == PH_CMD58 && bcnt == 0)
					return r < 65 ? {2'b11, any[5:0]} : any;
				if (ph == PH_WR_STATUS)
					return 8'h00;
				return any;
			end
			default: return r < 60 ? 8'h00 : any;
		endcase
	endfunction

	function automatic sdspi_pkg::sdspi_in_t next_item(output bit counted);
		sdspi_pkg::sdspi_in_t it;
		int r;
		it = mk_in(sdspi_pkg::KIND_RX, 2'($urandom), $urandom, $urandom, 8'($urandom),
			9'($urandom), 8'($urandom));
		if (it.block_count == 0)
			it.block_count = 32'd1;
		r = $urandom_range(0, 99);
		counted = 1'b1;
		if (ph == PH_IDLE) begin
			if (r < 8) begin
				counted = 1'b0;
			end else if (r < 12) begin
				it.kind = KIND_NONE;
				counted = 1'b0;
			end else if (r < 18) begin
				it.kind = sdspi_pkg::KIND_BUF;
			end else begin
				it.kind = sdspi_pkg::KIND_REQ;
				r = $urandom_range(0, 99);
				it.request = r < 35 ? sdspi_pkg::REQ_INIT : r < 55 ? sdspi_pkg::REQ_READ
					: r < 75 ? sdspi_pkg::REQ_WRITE : REQ_ERASE;
				// small erase counts mostly, full range now and then
				if (r >= 75 && $urandom_range(0, 3) != 0)
					it.block_count = $urandom_range(1, 8);
			end
		end else begin
			if (r < 4) begin
				it.kind = sdspi_pkg::KIND_REQ;
				counted = 1'b0;
			end else if (r < 8) begin
				it.kind = sdspi_pkg::KIND_BUF;
			end else if (r < 10) begin
				it.kind = KIND_NONE;
				counted = 1'b0;
			end else begin
				it.rx_byte = card_reply();
			end
		end
		return it;
	endfunction

	task automatic drive(input sdspi_pkg::sdspi_in_t it, input bit typed,
			input sdspi_pkg::sdspi_out_t tv);
		int gap;
		sdspi_pkg::sdspi_out_t p;
		if ($urandom_range(0, 99) == 0)
			burst = !burst;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		p = seq_step(it);
		seq_results_q.push_back(typed ? tv : p);
	endtask

	task automatic settle();
		@(negedge clk) in_ch.valid <= 1'b0;
		while (seq_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk) cfg_we <= 1'b0;
		case (idx)
			sdspi_pkg::CFG_R1_POLL: poll_lim = val;
			sdspi_pkg::CFG_RETRY: retry_lim = val[7:0];
			default: warm_len = val[7:0];
		endcase
	endtask

	task automatic run_random(input int n);
		int cnt;
		bit counted;
		sdspi_pkg::sdspi_in_t it;
		cnt = 0;
		while (cnt < n || ph != PH_IDLE) begin
			it = next_item(counted);
			drive(it, 1'b0, '0);
			if (counted)
				cnt++;
		end
	endtask

	function automatic void check_res(input sdspi_pkg::sdspi_out_t e,
			input sdspi_pkg::sdspi_out_t a);
		if (a.tx_byte != e.tx_byte) begin
			$error("tx_byte exp %h got %h", e.tx_byte, a.tx_byte); errors++;
		end
		if (a.tx_valid != e.tx_valid) begin
			$error("tx_valid exp %b got %b", e.tx_valid, a.tx_valid); errors++;
		end
		if (a.select_active != e.select_active) begin
			$error("select_active exp %b got %b", e.select_active, a.select_active); errors++;
		end
		if (a.read_byte != e.read_byte) begin
			$error("read_byte exp %h got %h", e.read_byte, a.read_byte); errors++;
		end
		if (a.read_index != e.read_index) begin
			$error("read_index exp %0d got %0d", e.read_index, a.read_index); errors++;
		end
		if (a.read_valid != e.read_valid) begin
			$error("read_valid exp %b got %b", e.read_valid, a.read_valid); errors++;
		end
		if (a.done_res != e.done_res) begin
			$error("done_res exp %b got %b", e.done_res, a.done_res); errors++;
		end
		if (a.status != e.status) begin
			$error("status exp %0d got %0d", e.status, a.status); errors++;
		end
		if (a.card_v2 != e.card_v2) begin
			$error("card_v2 exp %b got %b", e.card_v2, a.card_v2); errors++;
		end
		if (a.card_high_capacity != e.card_high_capacity) begin
			$error("card_high_capacity exp %b got %b", e.card_high_capacity,
				a.card_high_capacity);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (seq_results_q.size() == 0) begin
				$error("result item with none expected");
				errors++;
			end else begin
				check_res(seq_results_q.pop_front(), out_ch.data);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sd_card_spi_host_sequencer regression: fail");
			$finish;
		end
	end

	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				@(negedge clk) out_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) out_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	initial begin
		row_t dir_q[$];
		sdspi_pkg::sdspi_out_t z;
		errors = 0;
		cycles = 0;
		burst = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sdspi_pkg::CFG_R1_POLL;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		poll_lim = 16'd10000;
		retry_lim = 8'd255;
		warm_len = 8'd10;
		ph = PH_IDLE;
		sg = SG_WAIT;
		bcnt = '0;
		pcnt = '0;
		rcnt = '0;
		foreach (resp[i]) resp[i] = '0;
		flags = '0;
		cur_addr = '0;
		end_addr = '0;
		z = '0;

		// directed: ignored kinds, buffer extremes, read with R1 error, erase, busy request
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_RX, 0, 0, 1, 8'h5a, 0, 0), 1, z});
		dir_q.push_back('{mk_in(KIND_NONE, 3, '1, '1, '1, '1, '1), 1, z});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_BUF, 0, 0, 1, 0, 9'd0, 8'h00), 1, z});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_BUF, 0, 0, 1, 0, 9'd511, 8'hff), 1, z});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_REQ, sdspi_pkg::REQ_READ, 32'hffff_ffff, 1,
			0, 0, 0), 1, mk_res(sdspi_pkg::BYTE_IDLE, 1, 1, 0, sdspi_pkg::ST_OK)});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_RX, 0, 0, 1, 8'h00, 0, 0), 1,
			mk_res(sdspi_pkg::BYTE_IDLE, 1, 1, 0, sdspi_pkg::ST_OK)});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_RX, 0, 0, 1, 8'hff, 0, 0), 1,
			mk_res(8'h51, 1, 1, 0, sdspi_pkg::ST_OK)});
		repeat (6) dir_q.push_back('{mk_in(sdspi_pkg::KIND_RX, 0, 0, 1, 8'hff, 0, 0), 0, z});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_RX, 0, 0, 1, 8'h80, 0, 0), 0, z});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_RX, 0, 0, 1, 8'h04, 0, 0), 1,
			mk_res(8'h00, 0, 0, 1, sdspi_pkg::ST_R1_ERROR)});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_REQ, REQ_ERASE, 0, 32'hffff_ffff, 0, 0, 0),
			0, z});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_REQ, sdspi_pkg::REQ_INIT, 0, 1, 0, 0, 0), 1,
			mk_res(8'h00, 0, 1, 0, sdspi_pkg::ST_OK)});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_BUF, 0, 0, 1, 0, 9'h155, 8'haa), 1,
			mk_res(8'h00, 0, 1, 0, sdspi_pkg::ST_OK)});
		dir_q.push_back('{mk_in(sdspi_pkg::KIND_RX, 0, 0, 1, 8'hff, 0, 0), 0, z});

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (dir_q[i])
			drive(dir_q[i].it, dir_q[i].typed, dir_q[i].res);

		// fill the whole block buffer before any write request can read it
		for (int i = 0; i < sdspi_pkg::BLOCK_BYTES; i++)
			drive(mk_in(sdspi_pkg::KIND_BUF, 2'($urandom), $urandom, $urandom, 8'($urandom),
				9'(i), 8'($urandom)), 1'b0, '0);
		run_random(RAND_ITEMS);
		settle();

		write_cfg(sdspi_pkg::CFG_R1_POLL, 16'd1);
		write_cfg(sdspi_pkg::CFG_RETRY, 16'd1);
		write_cfg(sdspi_pkg::CFG_WARMUP, 16'd10);
		run_random(RAND_ITEMS);
		settle();

		write_cfg(sdspi_pkg::CFG_R1_POLL, 16'hffff);
		write_cfg(sdspi_pkg::CFG_RETRY, 16'd255);
		write_cfg(sdspi_pkg::CFG_WARMUP, 16'd255);
		run_random(RAND_ITEMS);
		settle();

		write_cfg(sdspi_pkg::CFG_R1_POLL, 16'd4);
		write_cfg(sdspi_pkg::CFG_RETRY, 16'd3);
		write_cfg(sdspi_pkg::CFG_WARMUP, 16'd12);
		run_random(RAND_ITEMS);
		settle();

		if (errors == 0)
			$display("sd_card_spi_host_sequencer regression: pass");
		else
			$display("sd_card_spi_host_sequencer regression: fail");
		$finish;
	end

endmodule

// ===== sd_card_spi_host_sequencer.f =====
+incdir+rtl/core
rtl/core/sdspi_pkg.sv
rtl/core/sdspi_in_if.sv
rtl/core/sdspi_out_if.sv
rtl/core/sd_card_spi_host_sequencer.sv
dv/sd_card_spi_host_sequencer_test.sv
